// File: rtl/srsc_pkg.sv
package srsc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 7;

    localparam logic [REQ_W-1:0] REQ_CALL        = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RETURN      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEW_PROCESS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CONTINUE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FINISH   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd6;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

    function automatic logic [DEPTH_OUT_W-1:0] depth_out(input count_t cnt);
        logic [CNT_W+DEPTH_OUT_W-1:0] wide;
        wide = {{DEPTH_OUT_W{1'b0}}, cnt};
        return wide[DEPTH_OUT_W-1:0];
    endfunction

endpackage

// File: rtl/srsc_cell.sv
module srsc_cell (
    input  logic                clk,
    input  srsc_pkg::shift_ctl_t ctl,
    input  srsc_pkg::addr_t     up_data,
    input  srsc_pkg::addr_t     down_data,
    output srsc_pkg::addr_t     data
);
    import srsc_pkg::*;

    addr_t data_reg;
    addr_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = up_data;
        end
        else if (ctl.pop)
        begin
            data_next = down_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/srsc_ctrl.sv
module srsc_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [srsc_pkg::REQ_W-1:0]          req_type,
    input  srsc_pkg::addr_t                     return_address,
    input  srsc_pkg::addr_t                     top_data,
    output srsc_pkg::shift_ctl_t                ctl,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [srsc_pkg::STATUS_W-1:0]       status,
    output logic [srsc_pkg::DEPTH_OUT_W-1:0]    stack_depth
);
    import srsc_pkg::*;

    count_t                  count_reg;
    count_t                  count_next;
    logic                    halted_reg;
    logic                    halted_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic [DEPTH_OUT_W-1:0]  depth_reg;
    logic                    accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        count_next  = count_reg;
        halted_next = halted_reg;
        status_next = status_reg;
        ctl         = '0;
        if (accept)
        begin
            if (halted_reg)
            begin
                status_next = ST_HALTED;
            end
            else
            begin
                case (req_type)
                    REQ_CALL:
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            halted_next = 1'b1;
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ctl.push    = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_PUSHED;
                        end
                    end
                    REQ_RETURN:
                    begin
                        if (count_reg == '0 || top_data != return_address)
                        begin
                            halted_next = 1'b1;
                            status_next = ST_MISMATCH;
                        end
                        else
                        begin
                            ctl.pop    = 1'b1;
                            count_next = count_reg - 1'b1;
                            if (count_reg == CNT_W'(1))
                            begin
                                halted_next = 1'b1;
                                status_next = ST_FINISH;
                            end
                            else
                            begin
                                status_next = ST_CONTINUE;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_IGNORED;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            depth_reg  <= depth_out(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign stack_depth = depth_reg;

`ifndef SYNTHESIS
    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.push && ctl.pop))
        else $error("push and pop together");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("count beyond stack depth");

    a_halted_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halted_reg) |=> (status_reg == ST_HALTED && $stable(count_reg)))
        else $error("word after halt not reported as halted");
`endif

endmodule

// File: rtl/shadow_return_stack_checker_unit.sv
// shadow return-address stack checker
// input channel: in_valid / in_ready carry one word per event, req_type
//   (call, return, new process) and the 64-bit return_address
// output channel: out_valid / out_ready carry one word per event, status
//   and stack_depth (entries held after the event, low 7 bits)
// the stack is a row of cells, top at cell 0; a call shifts the row down,
//   a matching return shifts it up, so only the top cell is compared
// the result word is registered and appears the cycle after the event is taken
// throughput: one event per cycle while out_ready takes each result word, set by the
//   shift of the row and the output register
// a mismatch, overflow or emptied stack halts the unit; every later event
//   is answered with halted until reset
// reset clears the count, the halt flag and the output valid; cell contents
//   are not cleared and are only read below the count
// when the receiver stalls, the output word holds and in_ready drops until
//   it is taken, so no event is lost
module shadow_return_stack_checker_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [srsc_pkg::REQ_W-1:0]          req_type,
    input  srsc_pkg::addr_t                     return_address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [srsc_pkg::STATUS_W-1:0]       status,
    output logic [srsc_pkg::DEPTH_OUT_W-1:0]    stack_depth
);
    import srsc_pkg::*;

    shift_ctl_t ctl;
    addr_t      cell_data [STACK_DEPTH];

    srsc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .return_address (return_address),
        .top_data       (cell_data[0]),
        .ctl            (ctl),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .stack_depth    (stack_depth)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        addr_t up_data;
        addr_t down_data;

        if (i == 0)
        begin : g_top
            assign up_data = return_address;
        end
        else
        begin : g_mid
            assign up_data = cell_data[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign down_data = cell_data[i];
        end
        else
        begin : g_inner
            assign down_data = cell_data[i+1];
        end

        srsc_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .up_data   (up_data),
            .down_data (down_data),
            .data      (cell_data[i])
        );
    end

endmodule

// File: tb/shadow_return_stack_checker_unit_tb.sv
`timescale 1ns / 1ps

module shadow_return_stack_checker_unit_tb;

    import srsc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WALK_MOVES = 1600;
    localparam int LONG_HOLD  = 300;

    typedef struct {
        logic [REQ_W-1:0] kind;
        addr_t            addr;
        int unsigned      gap;
    } stack_event_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [DEPTH_OUT_W-1:0] depth;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [REQ_W-1:0]       req_type = REQ_CALL;
    addr_t                  return_address = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [DEPTH_OUT_W-1:0] stack_depth;

    stack_event_t pending_events[$];
    verdict_t     expected_verdicts[$];
    addr_t        plan_stack[$];

    addr_t mirror_addr[STACK_DEPTH];
    int    mirror_count = 0;
    bit    mirror_halted = 1'b0;

    int error_count = 0;

    int unsigned  send_idle_left;
    stack_event_t next_word;
    int           send_calm_left = 0;
    bit           send_calm = 1'b0;

    int unsigned rx_stall_left;
    int unsigned rx_hold_left;
    int          rx_taken;
    int          rx_calm_left = 0;
    bit          rx_calm = 1'b0;

    verdict_t want;

    shadow_return_stack_checker_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .return_address (return_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .stack_depth    (stack_depth)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic verdict_t predict_verdict(input logic [REQ_W-1:0] kind, input addr_t addr);
        verdict_t v;
        v.status = ST_IGNORED;
        if (mirror_halted)
            v.status = ST_HALTED;
        else if (kind == REQ_CALL)
        begin
            if (mirror_count >= STACK_DEPTH)
            begin
                mirror_halted = 1'b1;
                v.status = ST_OVERFLOW;
            end
            else
            begin
                mirror_addr[mirror_count] = addr;
                mirror_count++;
                v.status = ST_PUSHED;
            end
        end
        else if (kind == REQ_RETURN)
        begin
            if (mirror_count == 0 || mirror_addr[mirror_count-1] != addr)
            begin
                mirror_halted = 1'b1;
                v.status = ST_MISMATCH;
            end
            else
            begin
                mirror_count--;
                if (mirror_count == 0)
                begin
                    mirror_halted = 1'b1;
                    v.status = ST_FINISH;
                end
                else
                    v.status = ST_CONTINUE;
            end
        end
        v.depth = DEPTH_OUT_W'(mirror_count);
        return v;
    endfunction

    function automatic addr_t random_address();
        return {$urandom, $urandom};
    endfunction

    function automatic addr_t pick_call_address();
        case ($urandom_range(0, 9))
            0, 1: return addr_t'($urandom_range(0, 255));
            2: return (plan_stack.size() > 0) ? plan_stack[$] : '1;
            3: return '1;
            default: return random_address();
        endcase
    endfunction

    task automatic add_item(input logic [REQ_W-1:0] kind, input addr_t addr);
        stack_event_t ev;
        if (send_calm_left == 0)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_calm_left = $urandom_range(20, 80);
        end
        send_calm_left--;
        ev.kind = kind;
        ev.addr = addr;
        ev.gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
        pending_events.push_back(ev);
    endtask

    task automatic plan_call(input addr_t addr);
        add_item(REQ_CALL, addr);
        plan_stack.push_back(addr);
    endtask

    task automatic plan_return();
        add_item(REQ_RETURN, plan_stack.pop_back());
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_CALL;
            return_address <= '0;
            send_idle_left = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_idle_left > 0)
            begin
                send_idle_left--;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                next_word = pending_events.pop_front();
                in_valid <= 1'b1;
                req_type <= next_word.kind;
                return_address <= next_word.addr;
                send_idle_left = next_word.gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver with random stalls and two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall_left = 0;
            rx_hold_left = 0;
            rx_taken = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                rx_taken++;
                if (rx_calm_left == 0)
                begin
                    rx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm_left = $urandom_range(20, 80);
                end
                rx_calm_left--;
                if (rx_taken == 400 || rx_taken == 1000)
                    rx_hold_left = LONG_HOLD;
                else if (!rx_calm && $urandom_range(0, 1) == 1)
                    rx_stall_left = $urandom_range(1, 15);
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: predict on every accepted word, check every result word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_verdicts.push_back(predict_verdict(req_type, return_address));
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected word: status %0d depth %0d", status, stack_depth);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (status !== want.status || stack_depth !== want.depth)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"word mismatch: expected status %0d depth %0d,",
                                      " got status %0d depth %0d"},
                                     want.status, want.depth, status, stack_depth);
                    end
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  walk_moves;
        int  goal;
        bit  go_up;

        // directed words, stack never runs dry here
        plan_call('0);
        plan_call('1);
        plan_return();
        plan_call(64'hAAAA_AAAA_AAAA_AAAA);
        plan_call(64'h5555_5555_5555_5555);
        add_item(REQ_NEW_PROCESS, '1);
        add_item(REQ_UNUSED, '0);
        add_item(REQ_UNUSED, '1);
        add_item(REQ_NEW_PROCESS, '0);
        plan_return();
        plan_call(64'h8000_0000_0000_0001);
        plan_call(64'h8000_0000_0000_0001);
        plan_return();
        plan_return();
        plan_call('0);
        plan_return();
        plan_return();

        // random walk of the depth between one entry and full
        walk_moves = 0;
        while (walk_moves < WALK_MOVES)
        begin
            case ($urandom_range(0, 3))
                0: goal = 1;
                1: goal = STACK_DEPTH;
                default: goal = $urandom_range(1, STACK_DEPTH);
            endcase
            do
            begin
                if ($urandom_range(0, 9) == 0)
                    add_item(($urandom_range(0, 1) == 1) ? REQ_NEW_PROCESS : REQ_UNUSED,
                             random_address());
                else
                begin
                    go_up = (plan_stack.size() < goal);
                    if (plan_stack.size() == goal || $urandom_range(0, 4) == 0)
                        go_up = ($urandom_range(0, 1) == 1);
                    if (plan_stack.size() >= STACK_DEPTH)
                        go_up = 1'b0;
                    if (plan_stack.size() <= 1)
                        go_up = 1'b1;
                    if (go_up)
                        plan_call(pick_call_address());
                    else
                        plan_return();
                    walk_moves++;
                end
            end
            while (plan_stack.size() != goal && walk_moves < WALK_MOVES);
        end

        // one halting word, then a tail that must all come back halted
        case ($urandom_range(0, 2))
            0:
            begin
                while (plan_stack.size() > 0)
                    plan_return();
            end
            1: add_item(REQ_RETURN, plan_stack[$] ^ (64'd1 << $urandom_range(0, 63)));
            default:
            begin
                while (plan_stack.size() < STACK_DEPTH)
                    plan_call(pick_call_address());
                add_item(REQ_CALL, random_address());
            end
        endcase
        repeat (12)
            add_item(REQ_W'($urandom_range(0, 3)), random_address());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/srsc_pkg.sv
rtl/srsc_cell.sv
rtl/srsc_ctrl.sv
rtl/shadow_return_stack_checker_unit.sv
tb/shadow_return_stack_checker_unit_tb.sv
